>>> hdl/mtlb_pkg.sv
package mtlb_pkg;

    localparam int NUM_ENTRIES = 32;

    // Widths of the configuration registers
    localparam int ASID_W = 8;
    localparam int EIU_W  = 6;
    localparam int CFG_W  = 8;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CURRENT_ASID   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_LEVEL    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENTRIES_IN_USE = 2'd2;

    localparam logic [EIU_W-1:0] EIU_RESET = 6'd32;

    // Request kinds
    localparam logic REQ_TRANSLATE = 1'b0;
    localparam logic REQ_WRITE     = 1'b1;

    // Privilege modes
    localparam logic [1:0] MODE_KERNEL = 2'd0;
    localparam logic [1:0] MODE_SUPER  = 2'd1;
    localparam logic [1:0] MODE_ALT_K  = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ADDR_ERR = 3'd1;
    localparam logic [2:0] ST_NO_MATCH = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_MODIFIED = 3'd4;

    // Segment bases
    localparam logic [31:0] KSEG0_BASE = 32'h8000_0000;
    localparam logic [31:0] KSEG1_BASE = 32'hA000_0000;
    localparam logic [31:0] KSEG2_BASE = 32'hC000_0000;
    localparam logic [31:0] KSEG3_BASE = 32'hE000_0000;

    localparam logic [12:0] PAGE_OFFSET_ONES = 13'h1FFF;

    typedef struct packed {
        logic        req_type;
        logic [31:0] virtual_address;
        logic        is_store;
        logic [1:0]  privilege_mode;
        logic [4:0]  entry_index;
        logic [18:0] entry_vpn2;
        logic [15:0] entry_page_mask;
        logic [7:0]  entry_asid;
        logic        entry_global;
        logic [3:0]  entry_flags;
        logic [23:0] entry_pfn_even;
        logic [23:0] entry_pfn_odd;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [35:0] physical_address;
        logic        writable;
    } out_item_t;

    // Request travelling down the entry chain
    typedef struct packed {
        in_item_t    req;
        logic        pending;   // mapped lookup not yet resolved
        logic [2:0]  status;
        logic [35:0] pa;
        logic        writable;
    } token_t;

    // Lookup controls broadcast to every cell
    typedef struct packed {
        logic [ASID_W-1:0] asid;
        logic [EIU_W-1:0]  entries_in_use;
    } lookup_ctl_t;

endpackage

>>> hdl/mtlb_cell.sv
module mtlb_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mtlb_pkg::EIU_W-1:0] cell_id,
    input  mtlb_pkg::lookup_ctl_t      ctl,
    input  logic                       tok_valid_in,
    input  mtlb_pkg::token_t           tok_in,
    output logic                       tok_valid_out,
    output mtlb_pkg::token_t           tok_out
);

    // Entry held by this cell
    logic [18:0] vpn2_reg;
    logic [7:0]  asid_reg;
    logic        global_reg;
    logic [15:0] mask_reg;
    logic [3:0]  flags_reg;
    logic [23:0] pfn_even_reg;
    logic [23:0] pfn_odd_reg;

    logic             tok_valid_reg;
    mtlb_pkg::token_t tok_reg;
    mtlb_pkg::token_t tok_next;

    logic        wr_here;
    logic [31:0] va;
    logic [31:0] mask32;
    logic [31:0] vbase;
    logic        asid_ok;
    logic        tag_ok;
    logic        in_range;
    logic        odd;
    logic        pg_valid;
    logic        pg_dirty;
    logic [23:0] pfn_sel;
    logic [35:0] off36;
    logic [35:0] pa_hit;
    logic        hit;

    assign va       = tok_in.req.virtual_address;
    assign wr_here  = tok_valid_in && (tok_in.req.req_type == mtlb_pkg::REQ_WRITE)
                      && (mtlb_pkg::EIU_W'(tok_in.req.entry_index) == cell_id);
    assign mask32   = {3'b000, mask_reg, mtlb_pkg::PAGE_OFFSET_ONES};
    assign vbase    = {vpn2_reg, 13'b0};
    assign asid_ok  = global_reg || (asid_reg == ctl.asid);
    assign tag_ok   = ((vbase ^ va) & ~mask32) == 32'b0;
    assign in_range = cell_id < ctl.entries_in_use;
    // lowest bit above the page offset picks odd or even page
    assign odd      = |(va & mask32 & ~(mask32 >> 1));
    assign pg_valid = odd ? flags_reg[2] : flags_reg[0];
    assign pg_dirty = odd ? flags_reg[3] : flags_reg[1];
    assign pfn_sel  = odd ? pfn_odd_reg : pfn_even_reg;
    assign off36    = 36'(mask32 >> 1);
    assign pa_hit   = ({pfn_sel, 12'b0} & ~off36) | (36'(va) & off36);

    assign hit = tok_valid_in && (tok_in.req.req_type == mtlb_pkg::REQ_TRANSLATE)
                 && tok_in.pending && in_range && asid_ok && tag_ok;

    always_comb
    begin
        tok_next = tok_in;
        if (hit)
        begin
            tok_next.pending = 1'b0;
            if (!pg_valid)
            begin
                tok_next.status   = mtlb_pkg::ST_INVALID;
                tok_next.pa       = '0;
                tok_next.writable = 1'b0;
            end
            else if (tok_in.req.is_store && !pg_dirty)
            begin
                tok_next.status   = mtlb_pkg::ST_MODIFIED;
                tok_next.pa       = '0;
                tok_next.writable = 1'b0;
            end
            else
            begin
                tok_next.status   = mtlb_pkg::ST_OK;
                tok_next.pa       = pa_hit;
                tok_next.writable = pg_dirty;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpn2_reg     <= '0;
            asid_reg     <= '0;
            global_reg   <= 1'b0;
            mask_reg     <= '0;
            flags_reg    <= '0;
            pfn_even_reg <= '0;
            pfn_odd_reg  <= '0;
        end
        else if (wr_here)
        begin
            vpn2_reg     <= tok_in.req.entry_vpn2;
            asid_reg     <= tok_in.req.entry_asid;
            global_reg   <= tok_in.req.entry_global;
            mask_reg     <= tok_in.req.entry_page_mask;
            flags_reg    <= tok_in.req.entry_flags;
            pfn_even_reg <= tok_in.req.entry_pfn_even;
            pfn_odd_reg  <= tok_in.req.entry_pfn_odd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_valid_in;
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

>>> hdl/mips32_tlb_address_translate.sv
// MIPS32 TLB address translation.
// Requests enter on start/request; one is taken at every clock edge where
// start is high and busy is low. busy never rises, so a request may be
// presented every cycle. A request is either a translate or a TLB entry write.
// The segment is decoded in a front stage, then the request walks a chain of
// NUM_ENTRIES cells, one TLB entry per cell, one cell per cycle. A write is
// taken by the cell whose slot it names; a translate is resolved by the first
// in-use cell whose tag matches, which keeps the lowest entry winning.
// A request passes the front stage register and NUM_ENTRIES cell registers;
// the result is taken at the edge ending the cycle in which it is shown.
// Throughput: one request per cycle. Each result is shown for one cycle with
// result_valid; the receiver cannot stall, results come out in request order.
// Reset clears every entry to zero (all pages invalid), current ASID to 0,
// error level to 1 and entries in use to 32. Configuration is written through
// cfg_write_en/cfg_index/cfg_data only while no request is in flight; the
// user must keep to this, since the block itself does not enforce it.
module mips32_tlb_address_translate (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  mtlb_pkg::in_item_t               request,
    input  logic                             cfg_write_en,
    input  logic [mtlb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mtlb_pkg::CFG_W-1:0]       cfg_data,
    output logic                             result_valid,
    output mtlb_pkg::out_item_t              result
);

    logic [mtlb_pkg::ASID_W-1:0] asid_reg;
    logic                        erl_reg;
    logic [mtlb_pkg::EIU_W-1:0]  eiu_reg;

    mtlb_pkg::lookup_ctl_t ctl;

    logic             accept;
    logic             kernel;
    logic             super_mode;
    logic [31:0]      va;
    mtlb_pkg::token_t front_next;
    mtlb_pkg::token_t front_reg;
    logic             front_valid_reg;

    logic             chain_valid [0:mtlb_pkg::NUM_ENTRIES];
    mtlb_pkg::token_t chain_tok   [0:mtlb_pkg::NUM_ENTRIES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            asid_reg <= '0;
            erl_reg  <= 1'b1;
            eiu_reg  <= mtlb_pkg::EIU_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                mtlb_pkg::CFG_CURRENT_ASID:   asid_reg <= cfg_data[mtlb_pkg::ASID_W-1:0];
                mtlb_pkg::CFG_ERROR_LEVEL:    erl_reg  <= cfg_data[0];
                mtlb_pkg::CFG_ENTRIES_IN_USE: eiu_reg  <= cfg_data[mtlb_pkg::EIU_W-1:0];
                default: ;
            endcase
        end
    end

    assign ctl.asid           = asid_reg;
    assign ctl.entries_in_use = eiu_reg;

    // Segment decode
    assign va         = request.virtual_address;
    assign kernel     = (request.privilege_mode == mtlb_pkg::MODE_KERNEL)
                        || (request.privilege_mode == mtlb_pkg::MODE_ALT_K);
    assign super_mode = request.privilege_mode == mtlb_pkg::MODE_SUPER;

    always_comb
    begin
        front_next          = '0;
        front_next.req      = request;
        front_next.status   = mtlb_pkg::ST_OK;
        front_next.pending  = 1'b0;
        front_next.pa       = '0;
        front_next.writable = 1'b0;
        if (request.req_type == mtlb_pkg::REQ_TRANSLATE)
        begin
            if (va < mtlb_pkg::KSEG0_BASE)
            begin
                if (erl_reg)
                begin
                    front_next.pa       = 36'(va);
                    front_next.writable = 1'b1;
                end
                else
                    front_next.pending = 1'b1;
            end
            else if (va < mtlb_pkg::KSEG1_BASE)
            begin
                if (kernel)
                begin
                    front_next.pa       = 36'(va - mtlb_pkg::KSEG0_BASE);
                    front_next.writable = 1'b1;
                end
                else
                    front_next.status = mtlb_pkg::ST_ADDR_ERR;
            end
            else if (va < mtlb_pkg::KSEG2_BASE)
            begin
                if (kernel)
                begin
                    front_next.pa       = 36'(va - mtlb_pkg::KSEG1_BASE);
                    front_next.writable = 1'b1;
                end
                else
                    front_next.status = mtlb_pkg::ST_ADDR_ERR;
            end
            else if (va < mtlb_pkg::KSEG3_BASE)
            begin
                if (kernel || super_mode)
                    front_next.pending = 1'b1;
                else
                    front_next.status = mtlb_pkg::ST_ADDR_ERR;
            end
            else
            begin
                if (kernel)
                    front_next.pending = 1'b1;
                else
                    front_next.status = mtlb_pkg::ST_ADDR_ERR;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else
            front_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
    end

    assign chain_valid[0] = front_valid_reg;
    assign chain_tok[0]   = front_reg;

    for (genvar g = 0; g < mtlb_pkg::NUM_ENTRIES; g++)
    begin : g_cell
        mtlb_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cell_id       (mtlb_pkg::EIU_W'(g)),
            .ctl           (ctl),
            .tok_valid_in  (chain_valid[g]),
            .tok_in        (chain_tok[g]),
            .tok_valid_out (chain_valid[g+1]),
            .tok_out       (chain_tok[g+1])
        );
    end

    // A lookup still pending after the last cell found no entry
    assign result_valid = chain_valid[mtlb_pkg::NUM_ENTRIES];
    always_comb
    begin
        if (chain_tok[mtlb_pkg::NUM_ENTRIES].pending)
        begin
            result.status           = mtlb_pkg::ST_NO_MATCH;
            result.physical_address = '0;
            result.writable         = 1'b0;
        end
        else
        begin
            result.status           = chain_tok[mtlb_pkg::NUM_ENTRIES].status;
            result.physical_address = chain_tok[mtlb_pkg::NUM_ENTRIES].pa;
            result.writable         = chain_tok[mtlb_pkg::NUM_ENTRIES].writable;
        end
    end

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_USER = 2'd2;
    localparam logic [mtlb_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int RAND_ITEMS = 1500;
    localparam int CALM_FROM  = 1300;

    typedef struct {
        bit                               is_cfg;
        logic [mtlb_pkg::CFG_INDEX_W-1:0] idx;
        logic [mtlb_pkg::CFG_W-1:0]       data;
        mtlb_pkg::in_item_t               req;
        bit                               typed;
        mtlb_pkg::out_item_t              exp;
    } plan_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    mtlb_pkg::in_item_t  request = '0;
    logic                cfg_write_en = 1'b0;
    logic [mtlb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [mtlb_pkg::CFG_W-1:0]       cfg_data = '0;
    logic                result_valid;
    mtlb_pkg::out_item_t result;

    // typed expectation for the directed rows, held alongside the request
    logic                given_typed = 1'b0;
    mtlb_pkg::out_item_t given_exp = '0;

    // translator copy: TLB contents and registers
    logic [18:0] slot_vpn2 [mtlb_pkg::NUM_ENTRIES];
    logic [15:0] slot_mask [mtlb_pkg::NUM_ENTRIES];
    logic [7:0]  slot_asid [mtlb_pkg::NUM_ENTRIES];
    logic        slot_glob [mtlb_pkg::NUM_ENTRIES];
    logic [3:0]  slot_flags [mtlb_pkg::NUM_ENTRIES];
    logic [23:0] slot_pfn_even [mtlb_pkg::NUM_ENTRIES];
    logic [23:0] slot_pfn_odd [mtlb_pkg::NUM_ENTRIES];
    logic [7:0]  run_asid = 8'd0;
    logic        run_erl = 1'b1;
    logic [5:0]  run_in_use = mtlb_pkg::EIU_RESET;

    mtlb_pkg::out_item_t pending_xlat [$];
    plan_row_t           plan [$];
    int                  errors = 0;

    mips32_tlb_address_translate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    always #4 clk = ~clk;

    initial
    begin
        for (int i = 0; i < mtlb_pkg::NUM_ENTRIES; i++)
        begin
            slot_vpn2[i] = '0;
            slot_mask[i] = '0;
            slot_asid[i] = '0;
            slot_glob[i] = 1'b0;
            slot_flags[i] = '0;
            slot_pfn_even[i] = '0;
            slot_pfn_odd[i] = '0;
        end
    end

    function automatic logic [2:0] tlb_search(input logic [31:0] va, input logic st,
                                              output logic [35:0] pa, output logic wr);
        int          lim;
        logic [31:0] vbase;
        logic [31:0] m;
        logic        odd;
        logic        v;
        logic        d;
        logic [23:0] pfn;
        logic [35:0] off;
        pa = '0;
        wr = 1'b0;
        lim = (run_in_use > mtlb_pkg::NUM_ENTRIES) ? mtlb_pkg::NUM_ENTRIES : int'(run_in_use);
        for (int i = 0; i < lim; i++)
        begin
            vbase = {slot_vpn2[i], 13'b0};
            m = {3'b0, slot_mask[i], mtlb_pkg::PAGE_OFFSET_ONES};
            if ((slot_glob[i] || slot_asid[i] == run_asid) && ((vbase & ~m) == (va & ~m)))
            begin
                // odd page chosen by the lowest bit above the page offset
                odd = |(va & m & ~(m >> 1));
                v = odd ? slot_flags[i][2] : slot_flags[i][0];
                d = odd ? slot_flags[i][3] : slot_flags[i][1];
                if (!v)
                    return mtlb_pkg::ST_INVALID;
                if (st && !d)
                    return mtlb_pkg::ST_MODIFIED;
                pfn = odd ? slot_pfn_odd[i] : slot_pfn_even[i];
                off = {4'b0, m >> 1};
                pa = ({pfn, 12'b0} & ~off) | ({4'b0, va} & off);
                wr = d;
                return mtlb_pkg::ST_OK;
            end
        end
        return mtlb_pkg::ST_NO_MATCH;
    endfunction

    function automatic mtlb_pkg::out_item_t translate_predict(input mtlb_pkg::in_item_t r);
        mtlb_pkg::out_item_t o;
        logic        kern;
        logic        sup;
        logic [31:0] va;
        o = '0;
        va = r.virtual_address;
        kern = (r.privilege_mode == mtlb_pkg::MODE_KERNEL)
               || (r.privilege_mode == mtlb_pkg::MODE_ALT_K);
        sup = (r.privilege_mode == mtlb_pkg::MODE_SUPER);
        if (r.req_type == mtlb_pkg::REQ_WRITE)
        begin
            slot_vpn2[r.entry_index] = r.entry_vpn2;
            slot_mask[r.entry_index] = r.entry_page_mask;
            slot_asid[r.entry_index] = r.entry_asid;
            slot_glob[r.entry_index] = r.entry_global;
            slot_flags[r.entry_index] = r.entry_flags;
            slot_pfn_even[r.entry_index] = r.entry_pfn_even;
            slot_pfn_odd[r.entry_index] = r.entry_pfn_odd;
            return o;
        end
        if (va < mtlb_pkg::KSEG0_BASE)
        begin
            if (run_erl)
            begin
                o.physical_address = {4'b0, va};
                o.writable = 1'b1;
            end
            else
                o.status = tlb_search(va, r.is_store, o.physical_address, o.writable);
        end
        else if (va < mtlb_pkg::KSEG1_BASE)
        begin
            if (kern)
            begin
                o.physical_address = {4'b0, va - mtlb_pkg::KSEG0_BASE};
                o.writable = 1'b1;
            end
            else
                o.status = mtlb_pkg::ST_ADDR_ERR;
        end
        else if (va < mtlb_pkg::KSEG2_BASE)
        begin
            if (kern)
            begin
                o.physical_address = {4'b0, va - mtlb_pkg::KSEG1_BASE};
                o.writable = 1'b1;
            end
            else
                o.status = mtlb_pkg::ST_ADDR_ERR;
        end
        else if (va < mtlb_pkg::KSEG3_BASE)
        begin
            if (kern || sup)
                o.status = tlb_search(va, r.is_store, o.physical_address, o.writable);
            else
                o.status = mtlb_pkg::ST_ADDR_ERR;
        end
        else
        begin
            if (kern)
                o.status = tlb_search(va, r.is_store, o.physical_address, o.writable);
            else
                o.status = mtlb_pkg::ST_ADDR_ERR;
        end
        if (o.status != mtlb_pkg::ST_OK)
        begin
            o.physical_address = '0;
            o.writable = 1'b0;
        end
        return o;
    endfunction

    // results checked, register writes tracked and requests predicted in one process
    always @(posedge clk)
    begin : monitor
        mtlb_pkg::out_item_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_xlat.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got status=%0d pa=%h wr=%b",
                         $time, result.status, result.physical_address, result.writable);
            end
            else
            begin
                want = pending_xlat.pop_front();
                if (result.status !== want.status
                    || result.physical_address !== want.physical_address
                    || result.writable !== want.writable)
                begin
                    errors++;
                    $display("%0t: expected st=%0d pa=%h wr=%b, got st=%0d pa=%h wr=%b",
                             $time, want.status, want.physical_address, want.writable,
                             result.status, result.physical_address, result.writable);
                end
            end
        end
        if (rst_n && cfg_write_en)
        begin
            case (cfg_index)
                mtlb_pkg::CFG_CURRENT_ASID:   run_asid = cfg_data[mtlb_pkg::ASID_W-1:0];
                mtlb_pkg::CFG_ERROR_LEVEL:    run_erl = cfg_data[0];
                mtlb_pkg::CFG_ENTRIES_IN_USE: run_in_use = cfg_data[mtlb_pkg::EIU_W-1:0];
                default: ;
            endcase
        end
        if (rst_n && start && busy === 1'b0)
        begin
            want = translate_predict(request);
            if (given_typed)
                want = given_exp;
            pending_xlat.push_back(want);
        end
    end

    task automatic send_request(input mtlb_pkg::in_item_t r, input bit typed,
                                input mtlb_pkg::out_item_t exp);
        @(negedge clk);
        start <= 1'b1;
        request <= r;
        given_typed <= typed;
        given_exp <= exp;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task automatic hold_off(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (pending_xlat.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [mtlb_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [mtlb_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    function automatic plan_row_t xlat_row(input logic [31:0] va, input logic st,
                                           input logic [1:0] mode);
        plan_row_t p;
        p = '{default: '0};
        p.req.req_type = mtlb_pkg::REQ_TRANSLATE;
        p.req.virtual_address = va;
        p.req.is_store = st;
        p.req.privilege_mode = mode;
        return p;
    endfunction

    function automatic plan_row_t fill_row(input logic [4:0] idx, input logic [18:0] vpn2,
                                           input logic [15:0] pmask, input logic [7:0] asid,
                                           input logic g, input logic [3:0] flags,
                                           input logic [23:0] pe, input logic [23:0] po);
        plan_row_t p;
        p = '{default: '0};
        p.req.req_type = mtlb_pkg::REQ_WRITE;
        p.req.entry_index = idx;
        p.req.entry_vpn2 = vpn2;
        p.req.entry_page_mask = pmask;
        p.req.entry_asid = asid;
        p.req.entry_global = g;
        p.req.entry_flags = flags;
        p.req.entry_pfn_even = pe;
        p.req.entry_pfn_odd = po;
        return p;
    endfunction

    function automatic plan_row_t reg_row(input logic [mtlb_pkg::CFG_INDEX_W-1:0] idx,
                                          input logic [mtlb_pkg::CFG_W-1:0] data);
        plan_row_t p;
        p = '{default: '0};
        p.is_cfg = 1'b1;
        p.idx = idx;
        p.data = data;
        return p;
    endfunction

    function automatic plan_row_t with_exp(input plan_row_t p, input logic [2:0] st,
                                           input logic [35:0] pa, input logic wr);
        p.typed = 1'b1;
        p.exp.status = st;
        p.exp.physical_address = pa;
        p.exp.writable = wr;
        return p;
    endfunction

    function automatic mtlb_pkg::in_item_t random_request;
        mtlb_pkg::in_item_t r;
        int          pick;
        int          slot;
        logic [31:0] m;
        logic [31:0] base;
        r.virtual_address = $urandom;
        r.is_store = 1'($urandom_range(0, 1));
        r.privilege_mode = 2'($urandom_range(0, 3));
        r.entry_index = 5'($urandom_range(0, mtlb_pkg::NUM_ENTRIES - 1));
        r.entry_vpn2 = 19'($urandom);
        r.entry_asid = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                                    : 8'($urandom_range(0, 255));
        r.entry_global = ($urandom_range(0, 3) == 0);
        r.entry_flags = 4'($urandom_range(0, 15));
        r.entry_pfn_even = 24'($urandom);
        r.entry_pfn_odd = 24'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: r.entry_page_mask = '0;
            6, 7, 8:          r.entry_page_mask = 16'hFFFF >> (2 * $urandom_range(0, 7));
            default:          r.entry_page_mask = 16'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 25)
            r.req_type = mtlb_pkg::REQ_WRITE;
        else
        begin
            r.req_type = mtlb_pkg::REQ_TRANSLATE;
            if (pick < 80)
            begin
                // aim inside a loaded page pair so lookups mostly resolve
                slot = $urandom_range(0, mtlb_pkg::NUM_ENTRIES - 1);
                m = {3'b0, slot_mask[slot], mtlb_pkg::PAGE_OFFSET_ONES};
                base = {slot_vpn2[slot], 13'b0};
                r.virtual_address = (base & ~m) | ($urandom & m);
            end
            else if (pick < 88)
            begin
                case ($urandom_range(0, 9))
                    0: r.virtual_address = 32'h0000_0000;
                    1: r.virtual_address = mtlb_pkg::KSEG0_BASE - 32'd1;
                    2: r.virtual_address = mtlb_pkg::KSEG0_BASE;
                    3: r.virtual_address = mtlb_pkg::KSEG1_BASE - 32'd1;
                    4: r.virtual_address = mtlb_pkg::KSEG1_BASE;
                    5: r.virtual_address = mtlb_pkg::KSEG2_BASE - 32'd1;
                    6: r.virtual_address = mtlb_pkg::KSEG2_BASE;
                    7: r.virtual_address = mtlb_pkg::KSEG3_BASE - 32'd1;
                    8: r.virtual_address = mtlb_pkg::KSEG3_BASE;
                    default: r.virtual_address = 32'hFFFF_FFFF;
                endcase
            end
        end
        return r;
    endfunction

    task automatic random_setting;
        logic [mtlb_pkg::CFG_W-1:0] v;
        if ($urandom_range(0, 9) < 7)
        begin
            case ($urandom_range(0, 9))
                0:       v = '0;
                1:       v = '1;
                2, 3:    v = mtlb_pkg::CFG_W'($urandom);
                default: v = mtlb_pkg::CFG_W'($urandom_range(0, 3));
            endcase
            write_reg(mtlb_pkg::CFG_CURRENT_ASID, v);
        end
        if ($urandom_range(0, 9) < 6)
        begin
            v = mtlb_pkg::CFG_W'($urandom);
            v[0] = ($urandom_range(0, 9) < 3);
            write_reg(mtlb_pkg::CFG_ERROR_LEVEL, v);
        end
        if ($urandom_range(0, 9) < 5)
        begin
            case ($urandom_range(0, 9))
                0:       v = 8'd0;
                1:       v = 8'd1;
                2:       v = mtlb_pkg::CFG_W'(mtlb_pkg::NUM_ENTRIES - 1);
                3:       v = mtlb_pkg::CFG_W'(mtlb_pkg::NUM_ENTRIES + 1);
                4:       v = '1;
                5:       v = mtlb_pkg::CFG_W'($urandom);
                default: v = mtlb_pkg::CFG_W'(mtlb_pkg::NUM_ENTRIES);
            endcase
            write_reg(mtlb_pkg::CFG_ENTRIES_IN_USE, v);
        end
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_UNUSED, mtlb_pkg::CFG_W'($urandom));
    endtask

    initial
    begin
        int sent;
        int n;
        bit calm;

        // reset state, registers at their reset values
        plan.push_back(with_exp(xlat_row(32'h0000_0000, 1'b0, mtlb_pkg::MODE_KERNEL),
                                mtlb_pkg::ST_OK, 36'h0, 1'b1));
        plan.push_back(with_exp(xlat_row(32'h7FFF_FFFF, 1'b1, MODE_USER),
                                mtlb_pkg::ST_OK, 36'h0_7FFF_FFFF, 1'b1));
        plan.push_back(with_exp(xlat_row(mtlb_pkg::KSEG0_BASE, 1'b0, mtlb_pkg::MODE_KERNEL),
                                mtlb_pkg::ST_OK, 36'h0, 1'b1));
        plan.push_back(with_exp(xlat_row(32'h9FFF_FFFF, 1'b1, MODE_USER),
                                mtlb_pkg::ST_ADDR_ERR, 36'h0, 1'b0));
        plan.push_back(with_exp(xlat_row(mtlb_pkg::KSEG1_BASE, 1'b1, mtlb_pkg::MODE_ALT_K),
                                mtlb_pkg::ST_OK, 36'h0, 1'b1));
        plan.push_back(with_exp(xlat_row(32'hBFFF_FFFF, 1'b0, mtlb_pkg::MODE_SUPER),
                                mtlb_pkg::ST_ADDR_ERR, 36'h0, 1'b0));
        plan.push_back(with_exp(xlat_row(mtlb_pkg::KSEG2_BASE, 1'b0, MODE_USER),
                                mtlb_pkg::ST_ADDR_ERR, 36'h0, 1'b0));
        plan.push_back(with_exp(xlat_row(mtlb_pkg::KSEG3_BASE, 1'b0, mtlb_pkg::MODE_SUPER),
                                mtlb_pkg::ST_ADDR_ERR, 36'h0, 1'b0));
        plan.push_back(with_exp(xlat_row(32'hDFFF_FFFF, 1'b0, mtlb_pkg::MODE_SUPER),
                                mtlb_pkg::ST_NO_MATCH, 36'h0, 1'b0));
        plan.push_back(with_exp(xlat_row(32'hFFFF_FFFF, 1'b1, mtlb_pkg::MODE_KERNEL),
                                mtlb_pkg::ST_NO_MATCH, 36'h0, 1'b0));
        plan.push_back(with_exp(fill_row(5'd0, 19'h60000, 16'h0000, 8'd5, 1'b0, 4'b0111,
                                         24'hFFFFFF, 24'h000001),
                                mtlb_pkg::ST_OK, 36'h0, 1'b0));
        plan.push_back(with_exp(fill_row(5'd31, 19'h7FFFF, 16'hFFFF, 8'hFF, 1'b1, 4'b1111,
                                         24'hFFFFFF, 24'hFFFFFF),
                                mtlb_pkg::ST_OK, 36'h0, 1'b0));
        // even page, odd page with D clear on a store, even page store
        plan.push_back(reg_row(mtlb_pkg::CFG_CURRENT_ASID, 8'd5));
        plan.push_back(xlat_row(mtlb_pkg::KSEG2_BASE, 1'b0, mtlb_pkg::MODE_KERNEL));
        plan.push_back(xlat_row(32'hC000_1000, 1'b1, mtlb_pkg::MODE_SUPER));
        plan.push_back(xlat_row(32'hC000_0FFF, 1'b1, mtlb_pkg::MODE_KERNEL));
        // global large page, PFN low bits taken from the address
        plan.push_back(reg_row(mtlb_pkg::CFG_CURRENT_ASID, 8'd63));
        plan.push_back(xlat_row(32'hE000_1234, 1'b1, mtlb_pkg::MODE_KERNEL));
        // mapped useg: invalid page, then a mask with gaps in it
        plan.push_back(reg_row(mtlb_pkg::CFG_ERROR_LEVEL, 8'd0));
        plan.push_back(with_exp(fill_row(5'd1, 19'h00000, 16'h0000, 8'd0, 1'b1, 4'b0000,
                                         24'h123456, 24'h654321),
                                mtlb_pkg::ST_OK, 36'h0, 1'b0));
        plan.push_back(xlat_row(32'h0000_0ABC, 1'b0, MODE_USER));
        plan.push_back(with_exp(fill_row(5'd2, 19'h00010, 16'h5555, 8'h3F, 1'b0, 4'b1100,
                                         24'hAAAAAA, 24'h555555),
                                mtlb_pkg::ST_OK, 36'h0, 1'b0));
        plan.push_back(xlat_row(32'h0002_2000, 1'b1, mtlb_pkg::MODE_ALT_K));
        // nothing searched, then a count above the table size
        plan.push_back(reg_row(mtlb_pkg::CFG_ENTRIES_IN_USE, 8'd0));
        plan.push_back(with_exp(xlat_row(32'h0000_0ABC, 1'b0, mtlb_pkg::MODE_KERNEL),
                                mtlb_pkg::ST_NO_MATCH, 36'h0, 1'b0));
        plan.push_back(reg_row(mtlb_pkg::CFG_ENTRIES_IN_USE, 8'd63));
        plan.push_back(reg_row(CFG_UNUSED, 8'd63));
        plan.push_back(xlat_row(32'hE000_1234, 1'b0, mtlb_pkg::MODE_KERNEL));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
                send_request(plan[i].req, plan[i].typed, plan[i].exp);
        end

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            drain();
            random_setting();
            n = $urandom_range(20, 80);
            calm = ($urandom_range(0, 2) == 0) || (sent >= CALM_FROM);
            repeat (n)
            begin
                if (!calm && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 10));
                send_request(random_request(), 1'b0, '0);
                sent++;
            end
        end

        drain();
        repeat (mtlb_pkg::NUM_ENTRIES + 8) @(negedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
